### hw/rtl/vac_pkg.sv
// vac_pkg: shared constants, types and helper function of the velocity autocorrelation core.
// No dependencies; compiled first.
package vac_pkg;

	localparam int MAX_ATOMS   = 64;
	localparam int MAX_FRAMES  = 63;
	localparam int SAMPLE_BITS = 24;

	localparam int ATOM_W      = $clog2(MAX_ATOMS);
	localparam int FRAME_W     = $clog2(MAX_FRAMES);
	localparam int FCNT_W      = FRAME_W + 1;
	localparam int ACNT_W      = ATOM_W + 1;
	localparam int STORE_DEPTH = MAX_FRAMES * MAX_ATOMS;
	localparam int ADDR_W      = FRAME_W + ATOM_W;
	localparam int CNT_W       = ADDR_W;
	localparam int SCALE_W     = 24;
	localparam int VAL_W       = 48;
	localparam int ACC_W       = 64;
	localparam int DIV_N_W     = 72;
	localparam int DIV_D_W     = 48;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int SUM_W       = VAL_W + 6;
	localparam int INT_W       = SUM_W + 2;
	localparam int MAG_W       = INT_W - 1;
	localparam int SPLIT       = 28;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATOM_COUNT = 3'd0,
		CFG_MAX_LAG    = 3'd1,
		CFG_USE_COORDS = 3'd2,
		CFG_NORMALIZE  = 3'd3,
		CFG_TIME_STEP  = 3'd4,
		CFG_VEL_SCALE  = 3'd5
	} cfg_idx_t;

	// output register source
	typedef enum logic [1:0] {
		OSEL_RAW  = 2'd0,
		OSEL_NORM = 2'd1,
		OSEL_INT  = 2'd2
	} out_sel_t;

	typedef enum logic [4:0] {
		S_LOAD,
		S_LDRAIN,
		S_PSETUP,
		S_MAC_INIT,
		S_MAC_RUN,
		S_MAC_DRAIN,
		S_DIV_LAG,
		S_DIV_LAG_WAIT,
		S_INT1,
		S_INT2,
		S_INT3,
		S_OUT_RD,
		S_OUT_CHK,
		S_NDIV_WAIT,
		S_OUT_WAIT,
		S_OUT_INT,
		S_OUT_IWAIT
	} state_t;

	typedef struct packed {
		logic [ACNT_W-1:0]  atom_count;
		logic [FRAME_W-1:0] max_lag;
		logic               use_coords;
		logic               normalize;
		logic [SCALE_W-1:0] time_step;
		logic [SCALE_W-1:0] vel_scale;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic               ld_v;
		logic               ld_store;
		logic               ld_coords;
		logic [ATOM_W-1:0]  ld_atom;
		logic [ADDR_W-1:0]  ld_addr;
		logic               pass_clr;
		logic               mac_clr;
		logic               mac_rd;
		logic [ADDR_W-1:0]  x_addr;
		logic [ADDR_W-1:0]  y_addr;
		logic               div_lag_start;
		logic               div_norm_start;
		logic [CNT_W-1:0]   count;
		logic               lag_wr;
		logic               lag_rd;
		logic [FRAME_W-1:0] lag_idx;
		logic               int_s1;
		logic               int_s2;
		logic               int_s3;
		logic               int_zero;
		logic               out_load;
		out_sel_t           out_sel;
		logic               ovf;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic ld_busy;
		logic mac_busy;
		logic div_busy;
		logic div_done;
		logic c0_zero;
		logic out_valid;
		logic out_taken;
	} status_t;

	// signed saturation of a magnitude to VAL_W bits
	function automatic logic signed [VAL_W-1:0] sat_mag(input logic [DIV_N_W-1:0] mag,
			input logic neg);
		logic [DIV_N_W-1:0] cap;
		logic [VAL_W-1:0]   m;
		cap = DIV_N_W'(1) << (VAL_W - 1);
		m   = mag[VAL_W-1:0];
		if (mag >= cap) begin
			return neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
		return neg ? $signed(-m) : $signed(m);
	endfunction

endpackage

### hw/rtl/vac_ifs.sv
// vac_ifs: valid/ready channel interfaces of the velocity autocorrelation core.
// Depends on vac_pkg.
interface vac_in_if;
	import vac_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] comp_x;
	logic signed [SAMPLE_BITS-1:0] comp_y;
	logic signed [SAMPLE_BITS-1:0] comp_z;
	logic                          final_item;
	modport source (output valid, comp_x, comp_y, comp_z, final_item, input ready);
	modport sink (input valid, comp_x, comp_y, comp_z, final_item, output ready);
endinterface

interface vac_out_if;
	import vac_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic [FRAME_W-1:0]      lag;
	logic signed [VAL_W-1:0] value;
	logic                    frames_overflow;
	logic                    last;
	modport source (output valid, kind, lag, value, frames_overflow, last, input ready);
	modport sink (input valid, kind, lag, value, frames_overflow, last, output ready);
endinterface

interface vac_cfg_if;
	import vac_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/vac_div.sv
// vac_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on vac_pkg.
module vac_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vac_pkg::DIV_N_W-1:0] dividend,
	input  logic [vac_pkg::DIV_D_W-1:0] divisor,
	output logic                        busy,
	output logic                        done,
	output logic [vac_pkg::DIV_N_W-1:0] quotient
);
	import vac_pkg::*;

	localparam int STEP_W = $clog2(DIV_N_W);

	logic [STEP_W-1:0]  step_q;
	logic               busy_q, done_q;
	logic [DIV_N_W-1:0] num_q;
	logic [DIV_D_W-1:0] den_q, rem_q, rem_next;
	logic [DIV_D_W:0]   trial;
	logic               qbit;

	// one trial subtraction per step
	always_comb begin
		trial    = {rem_q, num_q[DIV_N_W-1]};
		qbit     = (trial >= {1'b0, den_q});
		rem_next = qbit ? DIV_D_W'(trial - {1'b0, den_q}) : trial[DIV_D_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_N_W-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = num_q;

endmodule

### hw/rtl/vac_datapath.sv
// vac_datapath: sample scaling, velocity store, dot-product accumulator, lag store,
// integral and output register. Depends on vac_pkg, vac_ifs and vac_div.
module vac_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  vac_pkg::cfg_t                          cfg,
	input  vac_pkg::cmd_t                          cmd,
	input  logic signed [vac_pkg::SAMPLE_BITS-1:0] comp_x,
	input  logic signed [vac_pkg::SAMPLE_BITS-1:0] comp_y,
	input  logic signed [vac_pkg::SAMPLE_BITS-1:0] comp_z,
	output vac_pkg::status_t                       st,
	vac_out_if.source                              results
);
	import vac_pkg::*;

	localparam int D_W   = SAMPLE_BITS + 1;
	localparam int P_W   = D_W + SCALE_W + 1;
	localparam int R_W   = P_W + 1;
	localparam int SH_W  = R_W - 16;
	localparam int MP_W  = 2 * SAMPLE_BITS;

	// load pipeline control
	logic              ld_v_s1, ld_v_s2;
	logic              store_s1, store_s2, coords_s1;
	logic [ADDR_W-1:0] addr_s1, addr_s2;
	logic              rd_v_s1, prod_v_s2;

	logic signed [SAMPLE_BITS-1:0] samp [3];
	logic signed [MP_W-1:0]        mac_s2 [3];

	assign samp[0] = comp_x;
	assign samp[1] = comp_y;
	assign samp[2] = comp_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1   <= 1'b0;
			ld_v_s2   <= 1'b0;
			rd_v_s1   <= 1'b0;
			prod_v_s2 <= 1'b0;
		end else begin
			ld_v_s1   <= cmd.ld_v;
			ld_v_s2   <= ld_v_s1;
			rd_v_s1   <= cmd.mac_rd;
			prod_v_s2 <= rd_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		store_s1  <= cmd.ld_store;
		coords_s1 <= cmd.ld_coords;
		addr_s1   <= cmd.ld_addr;
		store_s2  <= store_s1;
		addr_s2   <= addr_s1;
	end

	// one lane per vector component
	for (genvar c = 0; c < 3; c++) begin : g_lane
		logic signed [SAMPLE_BITS-1:0] prev_mem [MAX_ATOMS];
		logic signed [SAMPLE_BITS-1:0] vel_mem [STORE_DEPTH];
		logic signed [SAMPLE_BITS-1:0] samp_s1, prev_s1, x_s1, y_s1, vel;
		logic signed [D_W-1:0]         diff;
		logic signed [P_W-1:0]         prod_s2;
		logic signed [R_W-1:0]         rnd;
		logic signed [SH_W-1:0]        shr;

		// previous coordinates: read old value, then overwrite
		always_ff @(posedge clk) begin
			if (cmd.ld_v) begin
				prev_s1 <= prev_mem[cmd.ld_atom];
				samp_s1 <= samp[c];
				if (cmd.ld_coords) begin
					prev_mem[cmd.ld_atom] <= samp[c];
				end
			end
		end

		// difference and scale
		always_comb begin
			diff = coords_s1 ? D_W'(samp_s1) - D_W'(prev_s1) : D_W'(samp_s1);
		end

		always_ff @(posedge clk) begin
			prod_s2 <= P_W'(diff) * $signed({1'b0, cfg.vel_scale});
		end

		// round half up, floor shift, saturate
		always_comb begin
			rnd = R_W'(prod_s2) + R_W'(32768);
			shr = SH_W'(rnd >>> 16);
			if (shr > SH_W'((1 <<< (SAMPLE_BITS - 1)) - 1)) begin
				vel = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			end else if (shr < -SH_W'(1 <<< (SAMPLE_BITS - 1))) begin
				vel = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			end else begin
				vel = SAMPLE_BITS'(shr);
			end
		end

		// velocity store: one write port, two read ports
		always_ff @(posedge clk) begin
			if (ld_v_s2 && store_s2) begin
				vel_mem[addr_s2] <= vel;
			end
			if (cmd.mac_rd) begin
				x_s1 <= vel_mem[cmd.x_addr];
				y_s1 <= vel_mem[cmd.y_addr];
			end
		end

		always_ff @(posedge clk) begin
			if (rd_v_s1) begin
				mac_s2[c] <= x_s1 * y_s1;
			end
		end
	end

	// dot-product accumulator, wraps at 64 bits
	logic signed [ACC_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (cmd.mac_clr) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + ACC_W'(mac_s2[0]) + ACC_W'(mac_s2[1]) + ACC_W'(mac_s2[2]);
		end
	end

	// shared divider
	logic                    div_start, div_busy, div_done, neg_q;
	logic [DIV_N_W-1:0]      div_num, div_q;
	logic [DIV_D_W-1:0]      div_den;
	logic [ACC_W-1:0]        acc_mag;
	logic signed [VAL_W-1:0] c0_q, clast_q, lag_rd_s1, cval;
	logic [VAL_W-1:0]        c_mag, c0_mag;

	always_comb begin
		acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		c_mag   = lag_rd_s1[VAL_W-1] ? VAL_W'(-lag_rd_s1) : VAL_W'(lag_rd_s1);
		c0_mag  = c0_q[VAL_W-1] ? VAL_W'(-c0_q) : VAL_W'(c0_q);
		div_start = cmd.div_lag_start || cmd.div_norm_start;
		if (cmd.div_norm_start) begin
			div_num = {c_mag, 24'd0};
			div_den = c0_mag;
		end else begin
			div_num = DIV_N_W'(acc_mag);
			div_den = DIV_D_W'(cmd.count);
		end
		cval = sat_mag(div_q, neg_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_lag_start) begin
			neg_q <= acc_q[ACC_W-1];
		end else if (cmd.div_norm_start) begin
			neg_q <= lag_rd_s1[VAL_W-1] ^ c0_q[VAL_W-1];
		end
	end

	vac_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	// lag store and running sums for the integral
	logic signed [VAL_W-1:0] lag_mem [MAX_FRAMES];
	logic signed [SUM_W-1:0] sum_q;

	always_ff @(posedge clk) begin
		if (cmd.lag_wr) begin
			lag_mem[cmd.lag_idx] <= cval;
		end
		if (cmd.lag_rd) begin
			lag_rd_s1 <= lag_mem[cmd.lag_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_clr) begin
			sum_q   <= '0;
			c0_q    <= '0;
			clast_q <= '0;
		end else if (cmd.lag_wr) begin
			sum_q   <= sum_q + SUM_W'(cval);
			clast_q <= cval;
			if (cmd.lag_idx == '0) begin
				c0_q <= cval;
			end
		end
	end

	// trapezoid integral: magnitude, two partial products, shift and saturate
	logic signed [INT_W-1:0]     isum;
	logic                        ineg_q;
	logic [MAG_W-1:0]            imag_q;
	logic [SPLIT+SCALE_W-1:0]    plo_q;
	logic [MAG_W-SPLIT+SCALE_W-1:0] phi_q;
	logic [MAG_W+SCALE_W-1:0]    iprod;
	logic signed [VAL_W-1:0]     total_q;

	always_comb begin
		isum  = (INT_W'(sum_q) <<< 1) - INT_W'(c0_q) - INT_W'(clast_q);
		iprod = (MAG_W+SCALE_W)'({phi_q, {SPLIT{1'b0}}}) + (MAG_W+SCALE_W)'(plo_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.int_s1) begin
			ineg_q <= isum[INT_W-1];
			imag_q <= isum[INT_W-1] ? MAG_W'(-isum) : MAG_W'(isum);
		end
		if (cmd.int_s2) begin
			plo_q <= imag_q[SPLIT-1:0] * cfg.time_step;
			phi_q <= imag_q[MAG_W-1:SPLIT] * cfg.time_step;
		end
		if (cmd.int_s3) begin
			total_q <= cmd.int_zero ? '0 :
				sat_mag(DIV_N_W'(iprod >> 17), ineg_q);
		end
	end

	// output register
	logic                    out_v_q, kind_q, last_q, ovf_q;
	logic [FRAME_W-1:0]      lag_q;
	logic signed [VAL_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_v_q <= 1'b1;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ovf_q <= cmd.ovf;
			unique case (cmd.out_sel)
				OSEL_RAW: begin
					kind_q  <= 1'b0;
					last_q  <= 1'b0;
					lag_q   <= cmd.lag_idx;
					value_q <= lag_rd_s1;
				end
				OSEL_NORM: begin
					kind_q  <= 1'b0;
					last_q  <= 1'b0;
					lag_q   <= cmd.lag_idx;
					value_q <= cval;
				end
				OSEL_INT: begin
					kind_q  <= 1'b1;
					last_q  <= 1'b1;
					lag_q   <= '0;
					value_q <= total_q;
				end
				default: begin
					kind_q  <= 1'b1;
					last_q  <= 1'b1;
					lag_q   <= '0;
					value_q <= total_q;
				end
			endcase
		end
	end

	assign results.valid           = out_v_q;
	assign results.kind            = kind_q;
	assign results.lag             = lag_q;
	assign results.value           = value_q;
	assign results.frames_overflow = ovf_q;
	assign results.last            = last_q;

	assign st.ld_busy   = ld_v_s1 || ld_v_s2;
	assign st.mac_busy  = rd_v_s1 || prod_v_s2;
	assign st.div_busy  = div_busy;
	assign st.div_done  = div_done;
	assign st.c0_zero   = (c0_q == '0);
	assign st.out_valid = out_v_q;
	assign st.out_taken = out_v_q && results.ready;

endmodule

### hw/rtl/vac_ctrl.sv
// vac_ctrl: controller of the velocity autocorrelation core: frame bookkeeping during
// load and the sequencer of the correlation pass. Depends on vac_pkg and vac_ifs.
module vac_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  vac_pkg::cfg_t    cfg,
	input  vac_pkg::status_t st,
	output vac_pkg::cmd_t    cmd,
	vac_in_if.sink           samples
);
	import vac_pkg::*;

	state_t state_q, state_d;

	logic [ATOM_W-1:0]  atom_idx_q, a_q;
	logic [FCNT_W-1:0]  frame_cnt_q;
	logic [FRAME_W-1:0] t_q, dt_q, lags_q, lags_d;
	logic               have_prev_q, ovf_q;

	logic [ACNT_W-1:0]  atoms;
	logic [FCNT_W-1:0]  nt;
	logic               in_fire, storing, st_en, end_frame, a_last, dt_last, t_last;

	// clamped atom count, loop bounds
	always_comb begin
		if (cfg.atom_count == '0) begin
			atoms = ACNT_W'(1);
		end else if (cfg.atom_count > ACNT_W'(MAX_ATOMS)) begin
			atoms = ACNT_W'(MAX_ATOMS);
		end else begin
			atoms = cfg.atom_count;
		end
		in_fire   = samples.valid && samples.ready;
		storing   = cfg.use_coords ? have_prev_q : 1'b1;
		st_en     = storing && (frame_cnt_q < FCNT_W'(MAX_FRAMES));
		end_frame = (ACNT_W'(atom_idx_q) + 1'b1 >= atoms) || samples.final_item;
		nt        = frame_cnt_q - FCNT_W'(t_q);
		a_last    = (ACNT_W'(a_q) + 1'b1 >= atoms);
		dt_last   = (FCNT_W'(dt_q) + 1'b1 == nt);
		t_last    = (t_q == lags_q - 1'b1);
		if (cfg.max_lag == '0) begin
			lags_d = FRAME_W'(frame_cnt_q >> 1);
		end else if (FCNT_W'(cfg.max_lag) > frame_cnt_q) begin
			lags_d = FRAME_W'(frame_cnt_q);
		end else begin
			lags_d = cfg.max_lag;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD:         if (in_fire && samples.final_item) state_d = S_LDRAIN;
			S_LDRAIN:       if (!st.ld_busy) state_d = S_PSETUP;
			S_PSETUP:       state_d = (lags_d == '0) ? S_INT1 : S_MAC_INIT;
			S_MAC_INIT:     state_d = S_MAC_RUN;
			S_MAC_RUN:      if (a_last && dt_last) state_d = S_MAC_DRAIN;
			S_MAC_DRAIN:    if (!st.mac_busy) state_d = S_DIV_LAG;
			S_DIV_LAG:      state_d = S_DIV_LAG_WAIT;
			S_DIV_LAG_WAIT: if (st.div_done) state_d = t_last ? S_INT1 : S_MAC_INIT;
			S_INT1:         state_d = S_INT2;
			S_INT2:         state_d = S_INT3;
			S_INT3:         state_d = (lags_q == '0) ? S_OUT_INT : S_OUT_RD;
			S_OUT_RD:       state_d = S_OUT_CHK;
			S_OUT_CHK:      state_d = (cfg.normalize && !st.c0_zero) ? S_NDIV_WAIT : S_OUT_WAIT;
			S_NDIV_WAIT:    if (st.div_done) state_d = S_OUT_WAIT;
			S_OUT_WAIT:     if (st.out_taken) state_d = t_last ? S_OUT_INT : S_OUT_RD;
			S_OUT_INT:      state_d = S_OUT_IWAIT;
			S_OUT_IWAIT:    if (st.out_taken) state_d = S_LOAD;
			default:        state_d = S_LOAD;
		endcase
	end

	// commands
	always_comb begin
		cmd            = '0;
		cmd.out_sel    = OSEL_RAW;
		cmd.ld_v       = in_fire;
		cmd.ld_store   = st_en;
		cmd.ld_coords  = cfg.use_coords;
		cmd.ld_atom    = atom_idx_q;
		cmd.ld_addr    = {FRAME_W'(frame_cnt_q), atom_idx_q};
		cmd.x_addr     = {dt_q, a_q};
		cmd.y_addr     = {FRAME_W'(dt_q + t_q), a_q};
		cmd.count      = CNT_W'(nt * atoms);
		cmd.lag_idx    = t_q;
		cmd.int_zero   = (lags_q < FRAME_W'(2));
		cmd.ovf        = ovf_q;
		unique case (state_q)
			S_PSETUP:       cmd.pass_clr = 1'b1;
			S_MAC_INIT:     cmd.mac_clr = 1'b1;
			S_MAC_RUN:      cmd.mac_rd = 1'b1;
			S_DIV_LAG:      cmd.div_lag_start = 1'b1;
			S_DIV_LAG_WAIT: cmd.lag_wr = st.div_done;
			S_INT1:         cmd.int_s1 = 1'b1;
			S_INT2:         cmd.int_s2 = 1'b1;
			S_INT3:         cmd.int_s3 = 1'b1;
			S_OUT_RD:       cmd.lag_rd = 1'b1;
			S_OUT_CHK: begin
				if (cfg.normalize && !st.c0_zero) begin
					cmd.div_norm_start = 1'b1;
				end else begin
					cmd.out_load = 1'b1;
				end
			end
			S_NDIV_WAIT: begin
				cmd.out_load = st.div_done;
				cmd.out_sel  = OSEL_NORM;
			end
			S_OUT_INT: begin
				cmd.out_load = 1'b1;
				cmd.out_sel  = OSEL_INT;
			end
			default: ;
		endcase
	end

	assign samples.ready = (state_q == S_LOAD);

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			atom_idx_q  <= '0;
			frame_cnt_q <= '0;
			have_prev_q <= 1'b0;
			ovf_q       <= 1'b0;
			t_q         <= '0;
			dt_q        <= '0;
			a_q         <= '0;
			lags_q      <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						if (storing && !st_en) ovf_q <= 1'b1;
						if (end_frame) begin
							atom_idx_q <= '0;
							if (st_en) frame_cnt_q <= frame_cnt_q + 1'b1;
							if (cfg.use_coords) have_prev_q <= 1'b1;
						end else begin
							atom_idx_q <= atom_idx_q + 1'b1;
						end
					end
				end
				S_PSETUP: begin
					lags_q <= lags_d;
					t_q    <= '0;
				end
				S_MAC_INIT: begin
					dt_q <= '0;
					a_q  <= '0;
				end
				S_MAC_RUN: begin
					if (a_last) begin
						a_q  <= '0;
						dt_q <= dt_q + 1'b1;
					end else begin
						a_q <= a_q + 1'b1;
					end
				end
				S_DIV_LAG_WAIT: begin
					if (st.div_done) t_q <= t_last ? '0 : t_q + 1'b1;
				end
				S_OUT_WAIT: begin
					if (st.out_taken && !t_last) t_q <= t_q + 1'b1;
				end
				S_OUT_IWAIT: begin
					if (st.out_taken) begin
						atom_idx_q  <= '0;
						frame_cnt_q <= '0;
						have_prev_q <= 1'b0;
						ovf_q       <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_lag_start || cmd.div_norm_start) |-> !st.div_busy)
		else $error("divider started while busy");
	a_out_free_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !st.out_valid)
		else $error("output register overwritten");
	a_frame_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frame_cnt_q <= FCNT_W'(MAX_FRAMES))
		else $error("frame count beyond store");
	a_lag_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC_RUN) |-> (t_q < lags_q && FCNT_W'(dt_q) < nt))
		else $error("correlation address out of range");
	a_pass_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT_IWAIT && st.out_taken) |=> (frame_cnt_q == '0 && !ovf_q))
		else $error("frame state not cleared after run");
`endif

endmodule

### hw/rtl/velocity_autocorrelation_core.sv
// Velocity autocorrelation core: top level with configuration registers.
// Depends on vac_pkg, vac_ifs, vac_ctrl, vac_datapath (and vac_div below it).
//
// Usage: write the configuration over cfg (always ready, one register per beat) while
// the core is idle. Then send atom vectors on samples, atoms in order within each frame;
// a beat is taken every cycle while loading, its store write passes the s1 and s2 load registers.
// The beat with final_item set ends its frame and starts the pass; samples.ready stays
// low until the last result beat has been taken.
// The pass runs on one multiply-accumulate pipe fed by two reads of the velocity store
// per cycle: lag t walks (frames - t) * atoms store addresses, then flushes the pipe
// and runs the 72-step bit-serial divide. Each normalized value needs another divide.
// Results: one beat per lag value (kind 0), then the integral (kind 1, last set).
// Each result sits in an output register until results.ready; a stalled receiver only
// holds the sequencer. After the final beat the frame state clears and loading resumes.
// Reset (arst_n low) clears the control state and sets the register defaults; the
// stores need no clearing pass.
module velocity_autocorrelation_core (
	input  logic      clk,
	input  logic      arst_n,
	vac_in_if.sink    samples,
	vac_out_if.source results,
	vac_cfg_if.sink   cfg
);
	import vac_pkg::*;

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t st;

	assign cfg.ready = 1'b1;

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.atom_count <= ACNT_W'(1);
			cfg_q.max_lag    <= '0;
			cfg_q.use_coords <= 1'b0;
			cfg_q.normalize  <= 1'b0;
			cfg_q.time_step  <= SCALE_W'(65536);
			cfg_q.vel_scale  <= SCALE_W'(65536);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ATOM_COUNT: cfg_q.atom_count <= cfg.data[ACNT_W-1:0];
				CFG_MAX_LAG:    cfg_q.max_lag    <= cfg.data[FRAME_W-1:0];
				CFG_USE_COORDS: cfg_q.use_coords <= cfg.data[0];
				CFG_NORMALIZE:  cfg_q.normalize  <= cfg.data[0];
				CFG_TIME_STEP:  cfg_q.time_step  <= cfg.data[SCALE_W-1:0];
				CFG_VEL_SCALE:  cfg_q.vel_scale  <= cfg.data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	vac_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.st      (st),
		.cmd     (cmd),
		.samples (samples)
	);

	vac_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cmd     (cmd),
		.comp_x  (samples.comp_x),
		.comp_y  (samples.comp_y),
		.comp_z  (samples.comp_z),
		.st      (st),
		.results (results)
	);

endmodule

### tb/sv/velocity_autocorrelation_core_test.sv
`timescale 1ns / 100ps
// velocity_autocorrelation_core_test: self-checking bench for the velocity autocorrelation core.
// Depends on vac_pkg, vac_ifs and the core; predicts every result beat and checks it in order.
module velocity_autocorrelation_core_test;
	import vac_pkg::*;

	localparam int  IDLE_LIMIT = 200000;
	localparam int  ITEM_TARGET = 460;
	localparam longint CAP48 = longint'(1) <<< 47;

	typedef struct packed {
		logic                    kind;
		logic [FRAME_W-1:0]      lag;
		logic signed [VAL_W-1:0] value;
		logic                    ovf;
		logic                    last;
	} vac_result_t;

	logic clk;
	logic arst_n;

	vac_in_if  smp();
	vac_out_if res();
	vac_cfg_if cfg_ch();

	velocity_autocorrelation_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp),
		.results (res),
		.cfg     (cfg_ch)
	);

	// predicted configuration and frame state
	int unsigned cnt_reg, lag_reg, coords_reg, norm_reg, tstep_reg, vscale_reg;
	logic signed [SAMPLE_BITS-1:0] vel_mem [MAX_FRAMES*MAX_ATOMS*3];
	logic signed [SAMPLE_BITS-1:0] prev_pos [MAX_ATOMS*3];
	int have_prev, frame_cnt, atom_idx, ovf_flag;
	longint lag_val [MAX_FRAMES];

	vac_result_t pending_results[$];
	int errors;
	int items_sent;
	int burst_left;
	bit no_gaps;
	int idle_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic longint clamp48(longint v);
		if (v > CAP48 - 1) return CAP48 - 1;
		if (v < -CAP48) return -CAP48;
		return v;
	endfunction

	function automatic longint capped(longint unsigned mag, bit neg);
		if (mag >= longint'(CAP48)) return neg ? -CAP48 : CAP48 - 1;
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] scale_comp(longint s);
		longint p;
		p = (s * longint'(vscale_reg) + 32768) >>> 16;
		if (p > 8388607) p = 8388607;
		if (p < -8388608) p = -8388608;
		return p[SAMPLE_BITS-1:0];
	endfunction

	function automatic longint norm_ratio(longint c, longint c0);
		longint unsigned d, m, q, r, acc;
		bit neg;
		d = c0 < 0 ? -c0 : c0;
		m = c < 0 ? -c : c;
		q = m / d;
		r = m % d;
		neg = (c < 0) != (c0 < 0);
		if (q >= (64'd1 << 23)) return capped(64'd1 << 47, neg);
		acc = q;
		for (int i = 0; i < 24; i++) begin
			acc = acc << 1;
			r = r << 1;
			if (r >= d) begin
				r = r - d;
				acc = acc | 1;
			end
		end
		return capped(acc, neg);
	endfunction

	function automatic void push_result(bit kind, int lag, longint v, bit last);
		vac_result_t e;
		e.kind  = kind;
		e.lag   = lag[FRAME_W-1:0];
		e.value = v[VAL_W-1:0];
		e.ovf   = ovf_flag[0];
		e.last  = last;
		pending_results.push_back(e);
	endfunction

	// correlation pass over the stored frames
	function automatic void run_correlation(int atoms);
		int n, lags;
		longint acc, s, total, v;
		longint unsigned mag;
		n = frame_cnt;
		if (lag_reg == 0) lags = n / 2;
		else if (int'(lag_reg) > n) lags = n;
		else lags = lag_reg;
		for (int t = 0; t < lags; t++) begin
			acc = 0;
			for (int f = 0; f < n - t; f++)
				for (int a = 0; a < atoms; a++)
					for (int c = 0; c < 3; c++)
						acc += longint'(vel_mem[(f*MAX_ATOMS + a)*3 + c]) *
							longint'(vel_mem[((f + t)*MAX_ATOMS + a)*3 + c]);
			lag_val[t] = clamp48(acc / longint'((n - t) * atoms));
		end
		total = 0;
		if (lags >= 2) begin
			s = lag_val[0] + lag_val[lags-1];
			for (int t = 1; t < lags - 1; t++) s += 2 * lag_val[t];
			mag = s < 0 ? -s : s;
			mag = (mag >> 17) * tstep_reg + (((mag & 64'h1FFFF) * tstep_reg) >> 17);
			total = capped(mag, s < 0);
		end
		for (int t = 0; t < lags; t++) begin
			v = lag_val[t];
			if (norm_reg != 0 && lag_val[0] != 0) v = norm_ratio(v, lag_val[0]);
			push_result(1'b0, t, v, 1'b0);
		end
		push_result(1'b1, 0, total, 1'b1);
		frame_cnt = 0;
		atom_idx  = 0;
		have_prev = 0;
		ovf_flag  = 0;
	endfunction

	// one accepted atom vector
	function automatic void feed_vector(logic signed [SAMPLE_BITS-1:0] comp [3], bit fin);
		int atoms, storing, slot;
		longint s, d;
		atoms = cnt_reg == 0 ? 1 : (cnt_reg > MAX_ATOMS ? MAX_ATOMS : cnt_reg);
		storing = coords_reg != 0 ? have_prev : 1;
		if (storing != 0 && frame_cnt >= MAX_FRAMES) ovf_flag = 1;
		for (int c = 0; c < 3; c++) begin
			s = longint'(comp[c]);
			slot = atom_idx * 3 + c;
			if (storing != 0 && frame_cnt < MAX_FRAMES) begin
				d = coords_reg != 0 ? s - longint'(prev_pos[slot]) : s;
				vel_mem[(frame_cnt*MAX_ATOMS + atom_idx)*3 + c] = scale_comp(d);
			end
			if (coords_reg != 0) prev_pos[slot] = comp[c];
		end
		if (atom_idx + 1 >= atoms || fin) begin
			atom_idx = 0;
			if (storing != 0 && frame_cnt < MAX_FRAMES) frame_cnt++;
			if (coords_reg != 0) have_prev = 1;
		end else begin
			atom_idx++;
		end
		if (fin) run_correlation(atoms);
	endfunction

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		vac_result_t e;
		if (arst_n && res.valid && res.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat kind=%0d lag=%0d value=%0d", $time,
					res.kind, res.lag, res.value);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (res.kind !== e.kind || res.lag !== e.lag || res.value !== e.value ||
						res.frames_overflow !== e.ovf || res.last !== e.last) begin
					$display("%0t: mismatch expected kind=%0d lag=%0d value=%0d ovf=%0d last=%0d",
						$time, e.kind, e.lag, e.value, e.ovf, e.last);
					$display("%0t:          actual kind=%0d lag=%0d value=%0d ovf=%0d last=%0d",
						$time, res.kind, res.lag, res.value, res.frames_overflow, res.last);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern: mode is redrawn whenever rdy_cycle[6:0] wraps to zero
	int unsigned rdy_cycle;
	int unsigned rdy_mode;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_cycle <= 0;
			rdy_mode  <= 0;
			res.ready <= 1'b0;
		end else begin
			rdy_cycle <= rdy_cycle + 1;
			if (rdy_cycle[6:0] == 0) rdy_mode <= $urandom_range(0, 3);
			case (rdy_mode)
				0: res.ready <= 1'b1;
				1: res.ready <= $urandom_range(0, 1);
				2: res.ready <= (rdy_cycle[1:0] == 2'd3);
				default: res.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready) || (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------- drivers ----------------
	task automatic write_reg(cfg_idx_t idx, int unsigned data);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_ATOM_COUNT: cnt_reg    = data & 32'h7F;
			CFG_MAX_LAG:    lag_reg    = data & 32'h3F;
			CFG_USE_COORDS: coords_reg = data & 1;
			CFG_NORMALIZE:  norm_reg   = data & 1;
			CFG_TIME_STEP:  tstep_reg  = data & 32'hFFFFFF;
			CFG_VEL_SCALE:  vscale_reg = data & 32'hFFFFFF;
			default: ;
		endcase
	endtask

	// send one atom vector; valid stays up inside a burst
	task automatic send_vector(logic signed [SAMPLE_BITS-1:0] x, logic signed [SAMPLE_BITS-1:0] y,
			logic signed [SAMPLE_BITS-1:0] z, bit fin);
		logic signed [SAMPLE_BITS-1:0] comp [3];
		comp[0] = x;
		comp[1] = y;
		comp[2] = z;
		smp.valid      <= 1'b1;
		smp.comp_x     <= x;
		smp.comp_y     <= y;
		smp.comp_z     <= z;
		smp.final_item <= fin;
		@(posedge clk);
		while (!smp.ready) @(posedge clk);
		feed_vector(comp, fin);
		items_sent++;
		if (!no_gaps && burst_left == 0) begin
			smp.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 15);
		end else if (burst_left > 0) begin
			burst_left--;
		end
	endtask

	// drain every expected beat, then let the core settle before touching registers
	task automatic wait_idle();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] rnd_comp();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return $signed(24'($urandom_range(0, 8191)) - 24'd4096);
			default: return $signed(24'($urandom));
		endcase
	endfunction

	// one run of whole frames ended by the final item
	task automatic send_run(int frames);
		int atoms;
		atoms = cnt_reg == 0 ? 1 : (cnt_reg > MAX_ATOMS ? MAX_ATOMS : cnt_reg);
		for (int f = 0; f < frames; f++)
			for (int a = 0; a < atoms; a++)
				send_vector(rnd_comp(), rnd_comp(), rnd_comp(), f == frames - 1 && a == atoms - 1);
		wait_idle();
	endtask

	// ---------------- tests ----------------
	task automatic test_defaults();
		send_vector(24'sd4096, -24'sd4096, 24'sd0, 1'b0);
		send_vector(24'sd2048, 24'sd1024, -24'sd1, 1'b0);
		send_vector(24'sd100, 24'sd200, 24'sd300, 1'b0);
		send_vector(-24'sd512, 24'sd7, 24'sd9, 1'b1);
		wait_idle();
	endtask

	task automatic test_extremes();
		write_reg(CFG_ATOM_COUNT, 2);
		write_reg(CFG_MAX_LAG, 63);
		write_reg(CFG_VEL_SCALE, 24'hFFFFFF);
		write_reg(CFG_TIME_STEP, 24'hFFFFFF);
		send_vector(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b0);
		send_vector(24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b0);
		send_vector(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
		send_vector(24'sh800000, 24'sh800000, 24'sh800000, 1'b0);
		send_vector(-24'sd1, 24'sd1, 24'sd0, 1'b0);
		send_vector(24'sh7FFFFF, 24'sh000000, 24'sh800000, 1'b1);
		wait_idle();
		write_reg(CFG_TIME_STEP, 1);
		write_reg(CFG_VEL_SCALE, 1);
		send_run(3);
	endtask

	// coordinate mode: first frame only remembered, a lone frame gives no lags
	task automatic test_coords();
		write_reg(CFG_USE_COORDS, 1);
		write_reg(CFG_ATOM_COUNT, 1);
		write_reg(CFG_VEL_SCALE, 65536);
		write_reg(CFG_TIME_STEP, 65536);
		send_vector(24'sh7FFFFF, 24'sh800000, 24'sd5, 1'b1);
		wait_idle();
		write_reg(CFG_ATOM_COUNT, 2);
		write_reg(CFG_NORMALIZE, 1);
		write_reg(CFG_MAX_LAG, 0);
		send_vector(24'sh800000, 24'sh7FFFFF, 24'sd0, 1'b0);
		send_vector(24'sd10, 24'sd20, 24'sd30, 1'b0);
		send_vector(24'sh7FFFFF, 24'sh800000, 24'sd1000, 1'b0);
		send_vector(24'sd40, -24'sd20, 24'sd0, 1'b0);
		send_vector(24'sd100, 24'sd0, 24'sd1, 1'b0);
		send_vector(24'sd44, -24'sd30, 24'sd9, 1'b1);
		wait_idle();
		write_reg(CFG_USE_COORDS, 0);
	endtask

	// lag-0 value of zero leaves normalization off
	task automatic test_zero_lag0();
		write_reg(CFG_VEL_SCALE, 0);
		write_reg(CFG_ATOM_COUNT, 1);
		send_run(4);
		write_reg(CFG_VEL_SCALE, 65536);
	endtask

	// early final item: missing atoms keep what an earlier run stored
	task automatic test_early_final();
		write_reg(CFG_ATOM_COUNT, 3);
		write_reg(CFG_MAX_LAG, 2);
		send_run(2);
		send_vector(24'sd300, 24'sd400, 24'sd500, 1'b0);
		send_vector(-24'sd300, 24'sd40, 24'sd50, 1'b0);
		send_vector(24'sd3, -24'sd4, 24'sd5, 1'b0);
		send_vector(24'sd777, 24'sd888, -24'sd999, 1'b1);
		wait_idle();
	endtask

	// atom counts out of range and a full store
	task automatic test_limits();
		write_reg(CFG_NORMALIZE, 0);
		write_reg(CFG_ATOM_COUNT, 0);
		write_reg(CFG_MAX_LAG, 0);
		send_run(5);
		write_reg(CFG_ATOM_COUNT, 100);
		send_run(2);
		write_reg(CFG_ATOM_COUNT, 64);
		write_reg(CFG_MAX_LAG, 1);
		send_run(2);
		write_reg(CFG_ATOM_COUNT, 1);
		write_reg(CFG_MAX_LAG, 63);
		send_run(MAX_FRAMES + 3);
		write_reg(CFG_MAX_LAG, 0);
		write_reg(CFG_NORMALIZE, 1);
		send_run(MAX_FRAMES + 1);
	endtask

	task automatic test_random();
		int frames, pick;
		while (items_sent < ITEM_TARGET) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1)) write_reg(CFG_MAX_LAG, $urandom_range(0, 63) % 9);
			if ($urandom_range(0, 2) == 0) write_reg(CFG_MAX_LAG, $urandom_range(0, 63));
			if ($urandom_range(0, 2) == 0) write_reg(CFG_USE_COORDS, $urandom_range(0, 1));
			if ($urandom_range(0, 2) == 0) write_reg(CFG_NORMALIZE, $urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0) write_reg(CFG_TIME_STEP, $urandom_range(1, 24'hFFFFFF));
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_VEL_SCALE, $urandom_range(0, 1) ? $urandom_range(0, 24'hFFFFFF) :
					$urandom_range(16384, 131072));
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				write_reg(CFG_ATOM_COUNT, $urandom_range(1, 4));
				frames = $urandom_range(1, 10);
			end else if (pick < 9) begin
				write_reg(CFG_ATOM_COUNT, $urandom_range(5, 16));
				frames = $urandom_range(1, 4);
			end else begin
				write_reg(CFG_ATOM_COUNT, $urandom_range(17, 127));
				frames = 2;
			end
			send_run(frames);
		end
		no_gaps = 1'b0;
	endtask

	// ---------------- sequence ----------------
	initial begin
		arst_n         = 1'b0;
		smp.valid      = 1'b0;
		smp.comp_x     = '0;
		smp.comp_y     = '0;
		smp.comp_z     = '0;
		smp.final_item = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = CFG_ATOM_COUNT;
		cfg_ch.data    = '0;
		errors      = 0;
		items_sent  = 0;
		burst_left  = 0;
		no_gaps     = 1'b0;
		idle_cycles = 0;
		cnt_reg = 1; lag_reg = 0; coords_reg = 0; norm_reg = 0;
		tstep_reg = 65536; vscale_reg = 65536;
		have_prev = 0; frame_cnt = 0; atom_idx = 0; ovf_flag = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_extremes();
		test_coords();
		test_zero_lag0();
		test_early_final();
		test_limits();
		test_random();

		wait_idle();
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### velocity_autocorrelation_core.f
hw/rtl/vac_pkg.sv
hw/rtl/vac_ifs.sv
hw/rtl/vac_div.sv
hw/rtl/vac_datapath.sv
hw/rtl/vac_ctrl.sv
hw/rtl/velocity_autocorrelation_core.sv
tb/sv/velocity_autocorrelation_core_test.sv
